// File: hdl/cstrip_pkg.sv
// Shared types and character constants for the C comment stripper.
`timescale 1ns / 1ps

package cstrip_pkg;

  // Character codes the lexer reacts to.
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Result queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Lexer states, one-hot.
  typedef enum logic [9:0] {
    ST_CODE   = 10'b00_0000_0001,
    ST_SLASH  = 10'b00_0000_0010,
    ST_BSLASH = 10'b00_0000_0100,
    ST_DQ     = 10'b00_0000_1000,
    ST_DQ_ESC = 10'b00_0001_0000,
    ST_SQ     = 10'b00_0010_0000,
    ST_SQ_ESC = 10'b00_0100_0000,
    ST_LINE   = 10'b00_1000_0000,
    ST_BLOCK  = 10'b01_0000_0000,
    ST_STAR   = 10'b10_0000_0000
  } lex_state_t;

  // Characters produced by one input byte.
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic       qerr;
    logic       err;
  } cstrip_emit_t;

  // One result transaction as held in the queue.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic       quote_error;
    logic       any_error;
  } cstrip_entry_t;

endpackage

// File: hdl/cstrip_lexer.sv
// Ten-state comment lexer: state registers and the per-byte transition logic.
`timescale 1ns / 1ps

module cstrip_lexer import cstrip_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   ch,
  output cstrip_emit_t emit
);

  lex_state_t state;
  lex_state_t state_next;
  logic       error_seen;
  logic       qerr;
  logic [1:0] cnt;
  logic [7:0] c0;
  logic [7:0] c1;

  // Transition and emission for the byte at the input register.
  always_comb begin
    state_next = ST_CODE;
    qerr       = 1'b0;
    cnt        = 2'd0;
    c0         = ch;
    c1         = ch;
    unique case (state)
      ST_SLASH: begin
        if (ch == CH_DQ) begin
          cnt = 2'd2; c0 = CH_SLASH; state_next = ST_DQ;
        end else if (ch == CH_SQ) begin
          cnt = 2'd2; c0 = CH_SLASH; state_next = ST_SQ;
        end else if (ch == CH_SLASH) begin
          cnt = 2'd1; c0 = CH_SPACE; state_next = ST_LINE;
        end else if (ch == CH_STAR) begin
          cnt = 2'd1; c0 = CH_SPACE; state_next = ST_BLOCK;
        end else if (ch == CH_BSL) begin
          state_next = ST_BSLASH;
        end else begin
          cnt = 2'd2; c0 = CH_SLASH; state_next = ST_CODE;
        end
      end
      ST_BSLASH: begin
        cnt = 2'd1; state_next = ST_CODE;
      end
      ST_DQ: begin
        cnt = 2'd1;
        if (ch == CH_NL) begin
          qerr = 1'b1; state_next = ST_CODE;
        end else if (ch == CH_BSL) begin
          state_next = ST_DQ_ESC;
        end else if (ch == CH_DQ) begin
          state_next = ST_CODE;
        end else begin
          state_next = ST_DQ;
        end
      end
      ST_SQ: begin
        cnt = 2'd1;
        if (ch == CH_NL) begin
          qerr = 1'b1; state_next = ST_CODE;
        end else if (ch == CH_BSL) begin
          state_next = ST_SQ_ESC;
        end else if (ch == CH_SQ) begin
          state_next = ST_CODE;
        end else begin
          state_next = ST_SQ;
        end
      end
      ST_DQ_ESC: begin
        cnt = 2'd1; state_next = ST_DQ;
      end
      ST_SQ_ESC: begin
        cnt = 2'd1; state_next = ST_SQ;
      end
      ST_LINE: begin
        if (ch == CH_NL) begin
          cnt = 2'd1; state_next = ST_CODE;
        end else if (ch == CH_BSL) begin
          state_next = ST_BSLASH;
        end else begin
          state_next = ST_LINE;
        end
      end
      ST_BLOCK: begin
        if (ch == CH_NL) begin
          cnt = 2'd1; state_next = ST_BLOCK;
        end else if (ch == CH_STAR) begin
          state_next = ST_STAR;
        end else begin
          state_next = ST_BLOCK;
        end
      end
      ST_STAR: begin
        if (ch == CH_SLASH) begin
          state_next = ST_CODE;
        end else if (ch == CH_STAR) begin
          state_next = ST_STAR;
        end else if (ch == CH_NL) begin
          cnt = 2'd1; state_next = ST_BLOCK;
        end else begin
          state_next = ST_BLOCK;
        end
      end
      // Normal code; any unreachable code behaves the same way.
      default: begin
        if (ch == CH_SLASH) begin
          state_next = ST_SLASH;
        end else begin
          cnt = 2'd1;
          if (ch == CH_DQ) begin
            state_next = ST_DQ;
          end else if (ch == CH_SQ) begin
            state_next = ST_SQ;
          end else begin
            state_next = ST_CODE;
          end
        end
      end
    endcase
  end

  assign emit.count = cnt;
  assign emit.ch0   = c0;
  assign emit.ch1   = c1;
  assign emit.qerr  = qerr;
  assign emit.err   = error_seen | qerr;

  // State update when the byte is committed to the result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CODE;
      error_seen <= 1'b0;
    end else if (step) begin
      state <= state_next;
      if (qerr) begin
        error_seen <= 1'b1;
      end
    end
  end

endmodule

// File: hdl/cstrip_queue.sv
// Result queue: takes up to two characters per cycle, gives out one per cycle while out_ready is high.
`timescale 1ns / 1ps

module cstrip_queue import cstrip_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_cnt,
  input  cstrip_entry_t push0,
  input  cstrip_entry_t push1,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output cstrip_entry_t out_entry
);

  cstrip_entry_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_p1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_entry = mem[rd_ptr];
  // Room for the largest burst of one byte.
  assign space     = (count <= CNT_W'(QUEUE_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr + PTR_W'(1);

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_cnt) - CNT_W'(pop);
    end
  end

endmodule

// File: hdl/c_comment_stripper.sv
// Top level of the C comment stripper stream block.
`timescale 1ns / 1ps

// Streams C source text one byte per transaction and returns the text with
// every comment replaced by a single space; newlines inside block comments
// are kept, and literals pass unchanged. Each input byte yields zero, one or
// two output transactions; m_tlast marks the final one of a byte. A newline
// inside an open string or char literal closes it and sets quote_error on
// that transaction, and any_error stays set from then on until reset.
// Throughput is one input byte per cycle while bytes yield at most one
// character each and m_tready stays high; the result queue drains one
// transaction per cycle. An accepted byte passes the input register and
// then the result queue before its first output transaction.

module c_comment_stripper import cstrip_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast,
  output logic [1:0] m_tuser    // [0] quote_error, [1] any_error
);

  logic          in_valid;
  logic [7:0]    in_ch;
  logic          step;
  logic          space;
  logic [1:0]    push_cnt;
  cstrip_emit_t  emit;
  cstrip_entry_t push0;
  cstrip_entry_t push1;
  cstrip_entry_t out_entry;

  assign step     = in_valid && space;
  assign s_tready = !in_valid || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch <= s_tdata;
    end
  end

  cstrip_lexer u_lexer (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ch   (in_ch),
    .emit (emit)
  );

  // Build queue entries from the lexer's emission.
  assign push_cnt          = step ? emit.count : 2'd0;
  assign push0.out_char    = emit.ch0;
  assign push0.last        = (emit.count == 2'd1);
  assign push0.quote_error = emit.qerr;
  assign push0.any_error   = emit.err;
  assign push1.out_char    = emit.ch1;
  assign push1.last        = 1'b1;
  assign push1.quote_error = emit.qerr;
  assign push1.any_error   = emit.err;

  cstrip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1),
    .space     (space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_entry (out_entry)
  );

  assign m_tdata = out_entry.out_char;
  assign m_tlast = out_entry.last;
  assign m_tuser = {out_entry.any_error, out_entry.quote_error};

endmodule

// File: hdl/cstrip_checker.sv
// Port-level checker for the C comment stripper, bound to the top level.
`timescale 1ns / 1ps

module cstrip_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);

  // A stalled result transaction holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result transaction changed");

  // The error flag is sticky across all later transactions.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |=> !m_tvalid || m_tuser[1])
    else $error("any_error dropped after being set");

  // A literal error always shows in the sticky flag too.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[1])
    else $error("quote_error without any_error");

  // A literal error comes only with a lone newline.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 8'h0A && m_tlast)
    else $error("quote_error on a character other than a lone newline");

endmodule

bind c_comment_stripper cstrip_checker u_cstrip_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// File: verif/c_strip_checker.sv
// Checker for the C comment stripper: predicts every output character and compares it.
`timescale 1ns / 1ps

module c_strip_checker import cstrip_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] out_char
  input  logic       m_tlast,
  input  logic [1:0] m_tuser,   // [0] quote_error, [1] any_error
  output int         mismatches,
  output int         chars_pending,
  output int         chars_checked,
  output int         literal_errors
);

  // Predicted lexer state and the characters still owed by the block.
  lex_state_t    lex_state = ST_CODE;
  logic          err_sticky = 1'b0;
  cstrip_entry_t expected_chars[$];
  int            mismatch_cnt = 0;
  int            checked_cnt = 0;
  int            qerr_cnt = 0;

  // One lexer step: the next state and the zero, one or two characters a byte yields.
  function automatic void lex_byte(input logic [7:0] c, input lex_state_t cur,
                                   output lex_state_t nxt, output int n,
                                   output logic [7:0] o0, output logic [7:0] o1,
                                   output logic qe);
    n   = 0;
    o0  = 8'h00;
    o1  = 8'h00;
    qe  = 1'b0;
    nxt = ST_CODE;
    case (cur)
      ST_SLASH: begin
        if (c == CH_DQ || c == CH_SQ) begin
          // A quote after a lone slash opens the literal.
          n = 2; o0 = CH_SLASH; o1 = c;
          nxt = (c == CH_DQ) ? ST_DQ : ST_SQ;
        end else if (c == CH_SLASH) begin
          n = 1; o0 = CH_SPACE; nxt = ST_LINE;
        end else if (c == CH_STAR) begin
          n = 1; o0 = CH_SPACE; nxt = ST_BLOCK;
        end else if (c == CH_BSL) begin
          nxt = ST_BSLASH;
        end else begin
          n = 2; o0 = CH_SLASH; o1 = c;
        end
      end
      ST_BSLASH: begin
        n = 1; o0 = c;
      end
      ST_DQ, ST_SQ: begin
        n = 1; o0 = c;
        if (c == CH_NL) begin
          // A newline closes an unterminated literal with an error.
          qe = 1'b1;
        end else if (c == CH_BSL) begin
          nxt = (cur == ST_DQ) ? ST_DQ_ESC : ST_SQ_ESC;
        end else if (c != ((cur == ST_DQ) ? CH_DQ : CH_SQ)) begin
          nxt = cur;
        end
      end
      ST_DQ_ESC: begin
        n = 1; o0 = c; nxt = ST_DQ;
      end
      ST_SQ_ESC: begin
        n = 1; o0 = c; nxt = ST_SQ;
      end
      ST_LINE: begin
        if (c == CH_NL) begin
          n = 1; o0 = CH_NL;
        end else if (c == CH_BSL) begin
          nxt = ST_BSLASH;
        end else begin
          nxt = ST_LINE;
        end
      end
      ST_BLOCK: begin
        if (c == CH_NL) begin
          n = 1; o0 = CH_NL; nxt = ST_BLOCK;
        end else if (c == CH_STAR) begin
          nxt = ST_STAR;
        end else begin
          nxt = ST_BLOCK;
        end
      end
      ST_STAR: begin
        // A run of stars keeps the pending star, so the comment closes on the slash.
        if (c == CH_STAR) begin
          nxt = ST_STAR;
        end else if (c == CH_NL) begin
          n = 1; o0 = CH_NL; nxt = ST_BLOCK;
        end else if (c != CH_SLASH) begin
          nxt = ST_BLOCK;
        end
      end
      default: begin
        if (c == CH_SLASH) begin
          nxt = ST_SLASH;
        end else begin
          n = 1; o0 = c;
          if (c == CH_DQ) nxt = ST_DQ;
          else if (c == CH_SQ) nxt = ST_SQ;
        end
      end
    endcase
  endfunction

  // Compare each output transaction, then predict from each input transaction.
  always @(posedge clk) begin : check_proc
    lex_state_t    nxt;
    int            n;
    logic [7:0]    o0, o1;
    logic          qe;
    cstrip_entry_t want, got;
    if (rst) begin
      lex_state  = ST_CODE;
      err_sticky = 1'b0;
      expected_chars.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.out_char    = m_tdata;
        got.last        = m_tlast;
        got.quote_error = m_tuser[0];
        got.any_error   = m_tuser[1];
        checked_cnt++;
        if (expected_chars.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: unexpected output char=%h last=%b quote_error=%b any_error=%b",
                     $realtime, got.out_char, got.last, got.quote_error, got.any_error);
          mismatch_cnt++;
        end else begin
          want = expected_chars.pop_front();
          if (got !== want) begin
            if (mismatch_cnt < 10) begin
              $display("%0t: output differs: expected char=%h last=%b quote_error=%b any_error=%b",
                       $realtime, want.out_char, want.last, want.quote_error, want.any_error);
              $display("%0t:                 actual   char=%h last=%b quote_error=%b any_error=%b",
                       $realtime, got.out_char, got.last, got.quote_error, got.any_error);
            end
            mismatch_cnt++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        lex_byte(s_tdata, lex_state, nxt, n, o0, o1, qe);
        lex_state = nxt;
        if (qe) begin
          err_sticky = 1'b1;
          qerr_cnt++;
        end
        for (int k = 0; k < n; k++) begin
          want.out_char    = (k == 0) ? o0 : o1;
          want.last        = (k == n - 1);
          want.quote_error = qe;
          want.any_error   = err_sticky;
          expected_chars.push_back(want);
        end
      end
    end
    mismatches     <= mismatch_cnt;
    chars_pending  <= expected_chars.size();
    chars_checked  <= checked_cnt;
    literal_errors <= qerr_cnt;
  end

endmodule

// File: verif/tb_top.sv
// Top of the C comment stripper testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top import cstrip_pkg::*;;

  localparam int DIRECTED_COUNT   = 25;
  localparam int RANDOM_PER_PHASE = 480;
  localparam int HOLD_CYCLES      = 150;
  localparam int DRAIN_CYCLES     = 8;
  localparam int CYCLE_LIMIT      = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;

  int   mismatches, chars_pending, chars_checked, literal_errors;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_req = 1'b0;
  int   bytes_sent = 0;
  int   cycle_count = 0;

  // Short directed text: slash before a newline, literal escapes and errors,
  // slash-quote, slash-backslash, star runs and newlines in a block comment,
  // and a backslash inside a line comment. Byte extremes ride along.
  logic [7:0] directed_bytes [DIRECTED_COUNT] = '{
    CH_SLASH, CH_NL,
    CH_DQ, CH_BSL, CH_NL, CH_NL,
    CH_SLASH, CH_SQ, CH_BSL, CH_SQ, CH_SQ,
    CH_SLASH, CH_BSL, 8'h00,
    CH_SLASH, CH_STAR, CH_STAR, CH_NL, CH_STAR, CH_STAR, CH_SLASH,
    CH_SLASH, CH_SLASH, CH_BSL, 8'hFF
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  c_comment_stripper dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  c_strip_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .m_tuser        (m_tuser),
    .mismatches     (mismatches),
    .chars_pending  (chars_pending),
    .chars_checked  (chars_checked),
    .literal_errors (literal_errors)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d characters outstanding.",
               cycle_count, chars_pending);
      $display("c_comment_stripper: mismatch");
      $finish;
    end
  end

  // Output side: random backpressure, or a long hold-off when requested.
  initial begin : recv_proc
    int   left;
    logic hold_taken;
    left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Any byte, with the characters the lexer reacts to drawn often.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(13))
      0: return CH_SLASH;
      1: return CH_STAR;
      2: return CH_BSL;
      3: return CH_NL;
      4: return CH_DQ;
      5: return CH_SQ;
      6: return CH_SPACE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Printable text that cannot close or escape a literal.
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(126, 32));
    if (c == CH_DQ || c == CH_SQ || c == CH_BSL) c = CH_SPACE;
    return c;
  endfunction

  // Offer one byte after a random gap and wait for its transaction.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Build one piece of C-like text with random content and send it.
  task automatic send_fragment();
    logic [7:0] frag[$];
    logic [7:0] quote;
    int         kind;
    int         len;
    kind = $urandom_range(9);
    case (kind)
      0: begin
        len = $urandom_range(6, 1);
        repeat (len) frag.push_back(pick_char());
      end
      1, 2: begin
        // Closed string or char literal with occasional escapes.
        quote = (kind == 1) ? CH_DQ : CH_SQ;
        frag.push_back(quote);
        len = $urandom_range(6);
        repeat (len) begin
          if ($urandom_range(9) == 0) begin
            frag.push_back(CH_BSL);
            frag.push_back(pick_char());
          end else begin
            frag.push_back(text_char());
          end
        end
        frag.push_back(quote);
      end
      3: begin
        // Line comment, sometimes with a backslash inside.
        frag.push_back(CH_SLASH);
        frag.push_back(CH_SLASH);
        len = $urandom_range(8);
        repeat (len) begin
          case ($urandom_range(7))
            0: begin
              frag.push_back(CH_BSL);
              frag.push_back(pick_char());
            end
            1: frag.push_back(8'($urandom_range(255)));
            default: frag.push_back(text_char());
          endcase
        end
        frag.push_back(CH_NL);
      end
      4: begin
        // Block comment with newlines and stars, closed by a run of stars.
        frag.push_back(CH_SLASH);
        frag.push_back(CH_STAR);
        len = $urandom_range(8);
        repeat (len) begin
          case ($urandom_range(5))
            0: frag.push_back(CH_NL);
            1: begin
              frag.push_back(CH_STAR);
              frag.push_back(CH_NL);
            end
            2: frag.push_back(CH_STAR);
            3: frag.push_back(8'($urandom_range(255)));
            default: frag.push_back(text_char());
          endcase
        end
        repeat ($urandom_range(3, 1)) frag.push_back(CH_STAR);
        frag.push_back(CH_SLASH);
      end
      5: begin
        // Literal left open until a newline.
        quote = $urandom_range(1) ? CH_DQ : CH_SQ;
        frag.push_back(quote);
        len = $urandom_range(4);
        repeat (len) frag.push_back(text_char());
        frag.push_back(CH_NL);
      end
      6: begin
        len = $urandom_range(4, 1);
        repeat (len) frag.push_back(8'($urandom_range(255)));
      end
      7: begin
        frag.push_back(CH_SLASH);
        frag.push_back(pick_char());
      end
      default: begin
        len = $urandom_range(10, 1);
        repeat (len) frag.push_back(($urandom_range(7) == 0) ? CH_NL : text_char());
      end
    endcase
    foreach (frag[i]) send_byte(frag[i]);
  endtask

  // Stop offering and wait until every predicted character has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  // Reset, directed text, then three random phases with different idling.
  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 57;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // Long output stall while input keeps coming, to fill the block.
          hold_req = 1'b1;
        end
      endcase
      while (bytes_sent < DIRECTED_COUNT + RANDOM_PER_PHASE * (phase + 1)) send_fragment();
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d source bytes of code, literals, escapes and comments,", bytes_sent);
    $display("with a long output stall; %0d characters checked, %0d literal errors.",
             chars_checked, literal_errors);
    if (chars_pending != 0)
      $display("%0d expected characters never came out.", chars_pending);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("c_comment_stripper: match");
    end else begin
      $display("c_comment_stripper: mismatch");
    end
    $finish;
  end

endmodule
